@@ rtl/u2u_pkg.sv @@
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-32 to UTF-16 byte-stream transcoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_BOM     = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_SURROGATE  = 3'd3,
        ST_RANGE      = 3'd4,
        ST_NONCHAR    = 3'd5
    } t_status;

    // Byte position that completes a group of four
    localparam logic [1:0] POS_LAST = 2'd3;

    // Most output bytes one input byte can cause
    localparam int GRP_BYTES = 4;
    localparam int GRP_CNT_W = $clog2(GRP_BYTES + 1);

    // Code point bounds
    localparam logic [31:0] CP_SURR_LO  = 32'h0000_D800;
    localparam logic [31:0] CP_SURR_HI  = 32'h0000_DFFF;
    localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
    localparam logic [31:0] CP_SUPP     = 32'h0001_0000;
    localparam logic [31:0] CP_NC_LO    = 32'h0000_FDD0;
    localparam logic [31:0] CP_NC_HI    = 32'h0000_FDEF;
    localparam logic [15:0] NC_MASK     = 16'hFFFE;
    localparam logic [15:0] LEAD_BASE   = 16'hD800;
    localparam logic [15:0] TRAIL_BASE  = 16'hDC00;
    localparam logic [15:0] TEN_MASK    = 16'h03FF;
    localparam logic [15:0] BOM_UNIT    = 16'hFEFF;
    localparam logic [7:0]  BYTE_FE     = 8'hFE;
    localparam logic [7:0]  BYTE_FF     = 8'hFF;

    // Stream control state
    typedef struct packed {
        logic       bom_seen;
        logic       little;
        logic [1:0] pos;
        logic       halted;
    } t_state;

    // Results caused by one input byte; bytes[0] goes out first
    typedef struct packed {
        logic [GRP_CNT_W-1:0]     cnt;
        logic [GRP_BYTES-1:0][7:0] bytes;
        t_status                  status;
    } t_group;

endpackage

@@ rtl/utf32_to_utf16_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// utf32_to_utf16_transcoder_core
// UTF-32 byte stream in, UTF-16 byte stream out, with BOM handling and
// a sticky error result.
// ----------------------------------------------------------------------------
//  channel | signals                                        | direction
//  input   | i_in_valid, o_in_ready, i_in_byte,             | in
//          | i_end_of_stream                                |
//  output  | o_out_valid, i_out_ready, o_out_byte,          | out
//          | o_status, o_last_of_run                        |
//
// With the ready signals high, one input byte is taken per cycle and its
// results appear in the next cycle; output bytes leave one per cycle, a group
// of up to four bytes draining while the next group's bytes arrive.
// A byte that would add results waits while the result register still holds
// a byte that does not leave in this cycle. Reset clears the stream state and
// the result register; after an error result every byte is taken and dropped.
// ----------------------------------------------------------------------------
module utf32_to_utf16_transcoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_stream,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_status,
    output logic       o_last_of_run
);
    import u2u_pkg::*;

    t_state      r_state, n_state;
    logic [23:0] r_gather, n_gather;
    t_group      grp;
    logic        buf_free;
    logic        in_acc;

    // Decode of the incoming byte
    u2u_step u_step (
        .i_cur          (r_state),
        .i_gather       (r_gather),
        .i_in_byte      (i_in_byte),
        .i_end_of_stream(i_end_of_stream),
        .o_nxt          (n_state),
        .o_gather       (n_gather),
        .o_grp          (grp)
    );

    // Ready: halted bytes and silent bytes never wait
    assign o_in_ready = r_state.halted || buf_free ||
                        ((r_state.pos != POS_LAST) && !i_end_of_stream);
    assign in_acc     = i_in_valid && o_in_ready;

    // Stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gather <= n_gather;
        end
    end

    // Result register
    u2u_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_acc && (grp.cnt != '0)),
        .i_grp        (grp),
        .o_free       (buf_free),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_last_of_run(o_last_of_run)
    );

`ifndef SYNTH
    // An error result is a single byte of zero
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_last_of_run && (o_out_byte == 8'h00)))
        else $error("error result not a single zero byte");

    // An error result is only shown once the stream has halted
    a_err_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> r_state.halted)
        else $error("error result without halt");

    // Code units only flow after the BOM was accepted
    a_ok_after_bom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK)) |-> r_state.bom_seen)
        else $error("output before byte order mark");
`endif

endmodule

@@ rtl/u2u_step.sv @@
// ----------------------------------------------------------------------------
// u2u_step
// Single-pass decode of one input byte: gathers group bytes, checks the BOM,
// assembles and validates the code point, and builds the UTF-16 byte group.
// ----------------------------------------------------------------------------
module u2u_step (
    input  u2u_pkg::t_state i_cur,
    input  logic [23:0]     i_gather,
    input  logic [7:0]      i_in_byte,
    input  logic            i_end_of_stream,
    output u2u_pkg::t_state o_nxt,
    output logic [23:0]     o_gather,
    output u2u_pkg::t_group o_grp
);
    import u2u_pkg::*;

    logic [7:0]  b0, b1, b2, b3;
    logic        bom_be, bom_le;
    logic [31:0] cp;
    logic [31:0] v;
    logic [15:0] lead, trail;
    logic        is_surr, is_range, is_nonchar;
    logic [15:0] bom_u, cp_u, lead_u, trail_u;

    // Code unit to bytes in the stream byte order, first byte in [15:8]
    function automatic logic [15:0] unit_bytes(input logic [15:0] u, input logic le);
        return le ? {u[7:0], u[15:8]} : u;
    endfunction

    // Group bytes and BOM match
    assign b0     = i_gather[23:16];
    assign b1     = i_gather[15:8];
    assign b2     = i_gather[7:0];
    assign b3     = i_in_byte;
    assign bom_be = (b0 == 8'h00) && (b1 == 8'h00) && (b2 == BYTE_FE) && (b3 == BYTE_FF);
    assign bom_le = (b0 == BYTE_FF) && (b1 == BYTE_FE) && (b2 == 8'h00) && (b3 == 8'h00);

    // Code point and checks
    assign cp = i_cur.little ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
    assign is_surr    = (cp >= CP_SURR_LO) && (cp <= CP_SURR_HI);
    assign is_range   = cp > CP_MAX;
    assign is_nonchar = ((cp[15:0] & NC_MASK) == NC_MASK) ||
                        ((cp >= CP_NC_LO) && (cp <= CP_NC_HI));

    // Surrogate pair
    assign v     = cp - CP_SUPP;
    assign lead  = LEAD_BASE + {6'd0, v[19:10]};
    assign trail = TRAIL_BASE + (v[15:0] & TEN_MASK);

    // Code units in stream byte order
    assign bom_u   = unit_bytes(BOM_UNIT, bom_le);
    assign cp_u    = unit_bytes(cp[15:0], i_cur.little);
    assign lead_u  = unit_bytes(lead, i_cur.little);
    assign trail_u = unit_bytes(trail, i_cur.little);

    always_comb begin
        o_nxt        = i_cur;
        o_gather     = i_gather;
        o_grp.cnt    = '0;
        o_grp.bytes  = '0;
        o_grp.status = ST_OK;
        if (i_cur.halted) begin
            // halted: drop the byte
        end else if (i_cur.pos != POS_LAST) begin
            // partial group
            case (i_cur.pos)
                2'd0:    o_gather[23:16] = i_in_byte;
                2'd1:    o_gather[15:8]  = i_in_byte;
                default: o_gather[7:0]   = i_in_byte;
            endcase
            o_nxt.pos = i_cur.pos + 2'd1;
            if (i_end_of_stream) begin
                o_grp.cnt    = GRP_CNT_W'(1);
                o_grp.status = ST_INCOMPLETE;
                o_nxt.halted = 1'b1;
            end
        end else begin
            o_nxt.pos = 2'd0;
            if (!i_cur.bom_seen) begin
                // byte order mark
                if (bom_be || bom_le) begin
                    o_nxt.bom_seen       = 1'b1;
                    o_nxt.little         = bom_le;
                    o_grp.cnt            = GRP_CNT_W'(2);
                    o_grp.bytes[1:0]     = {bom_u[7:0], bom_u[15:8]};
                end else begin
                    o_grp.cnt    = GRP_CNT_W'(1);
                    o_grp.status = ST_NO_BOM;
                    o_nxt.halted = 1'b1;
                end
            end else if (is_surr || is_range || is_nonchar) begin
                // invalid code point, checks in priority order
                o_grp.cnt    = GRP_CNT_W'(1);
                o_nxt.halted = 1'b1;
                if (is_surr) begin
                    o_grp.status = ST_SURROGATE;
                end else if (is_range) begin
                    o_grp.status = ST_RANGE;
                end else begin
                    o_grp.status = ST_NONCHAR;
                end
            end else if (cp < CP_SUPP) begin
                // basic plane: one code unit
                o_grp.cnt        = GRP_CNT_W'(2);
                o_grp.bytes[1:0] = {cp_u[7:0], cp_u[15:8]};
            end else begin
                // supplementary plane: surrogate pair
                o_grp.cnt   = GRP_CNT_W'(4);
                o_grp.bytes = {trail_u[7:0], trail_u[15:8],
                               lead_u[7:0], lead_u[15:8]};
            end
        end
    end

endmodule

@@ rtl/u2u_out_buf.sv @@
// ----------------------------------------------------------------------------
// u2u_out_buf
// Result register: holds one group of up to four output bytes and hands
// them out one per request.
// ----------------------------------------------------------------------------
module u2u_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  u2u_pkg::t_group i_grp,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic [2:0]      o_status,
    output logic            o_last_of_run
);
    import u2u_pkg::*;

    logic [GRP_CNT_W-1:0]      r_cnt, n_cnt;
    logic [GRP_BYTES-1:0][7:0] r_bytes, n_bytes;
    t_status                   r_status, n_status;
    logic                      pop;

    assign pop    = o_out_valid && i_out_ready;
    // empty by the next edge
    assign o_free = (r_cnt == '0) || ((r_cnt == GRP_CNT_W'(1)) && i_out_ready);

    // Load or shift
    always_comb begin
        n_cnt    = r_cnt;
        n_bytes  = r_bytes;
        n_status = r_status;
        if (i_load) begin
            n_cnt    = i_grp.cnt;
            n_bytes  = i_grp.bytes;
            n_status = i_grp.status;
        end else if (pop) begin
            n_cnt   = r_cnt - GRP_CNT_W'(1);
            n_bytes = r_bytes >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes  <= n_bytes;
        r_status <= n_status;
    end

    assign o_out_valid   = r_cnt != '0;
    assign o_out_byte    = r_bytes[0];
    assign o_status      = r_status;
    assign o_last_of_run = r_cnt == GRP_CNT_W'(1);

endmodule
